// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ECAL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequence checked at the clock edge after the antecedent.
`define ECAL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ecal_pkg.sv =====
`timescale 1ns / 1ps
package ecal_pkg;

  localparam int unsigned TsW   = 32;
  localparam int unsigned RemW  = 17;
  localparam int unsigned StepW = 6;
  localparam int unsigned DaysW = 16;
  localparam int unsigned YdayW = 9;

  localparam logic [RemW-1:0] SecsPerDay = 17'd86400;
  localparam logic [RemW-1:0] SixtyDiv   = 17'd60;
  localparam logic [RemW-1:0] WeekDiv    = 17'd7;

  localparam logic [StepW-1:0] StepsDay      = 6'd32;
  localparam logic [StepW-1:0] StepsTod      = 6'd17;
  localparam logic [StepW-1:0] StepsMinOfDay = 6'd11;
  localparam logic [StepW-1:0] StepsWeek     = 6'd16;

  localparam logic [DaysW-1:0] EpochWdayOfs = 16'd4;
  localparam logic [7:0]       EpochYearOfs = 8'd70;
  localparam logic [1:0]       EpochMod4    = 2'd2;
  localparam logic [6:0]       EpochMod100  = 7'd70;
  localparam logic [8:0]       EpochMod400  = 9'd370;
  localparam logic [6:0]       Mod100Last   = 7'd99;
  localparam logic [8:0]       Mod400Last   = 9'd399;

  localparam logic [YdayW-1:0] DaysCommon = 9'd365;
  localparam logic [YdayW-1:0] DaysLeap   = 9'd366;
  localparam logic [YdayW-1:0] LeapDay    = 9'd59;
  localparam logic [3:0]       MonthLast  = 4'd11;
  localparam logic [1:0]       MdayBase   = 2'd1;
  localparam logic [1:0]       MdayOnLeap = 2'd2;

  typedef struct packed {
    logic [TsW-1:0]   dividend;
    logic [StepW-1:0] steps;
    logic [RemW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic [7:0]       years;
    logic [YdayW-1:0] yday;
    logic [3:0]       month;
    logic [4:0]       mday;
  } cal_res_t;

  typedef enum logic [2:0] {
    CtlIdle, CtlDay, CtlMin, CtlHour, CtlWday, CtlCal, CtlLoad
  } ctl_state_e;

  typedef enum logic [1:0] {
    CalIdle, CalYear, CalMonth
  } cal_state_e;

  // First day of each month in a common year, zero based.
  function automatic logic [YdayW-1:0] month_start(input logic [3:0] mon);
    logic [YdayW-1:0] r;
    unique case (mon)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/ecal_in_if.sv =====
`timescale 1ns / 1ps
interface ecal_in_if;
  import ecal_pkg::*;
  logic           valid;
  logic           ready;
  logic [TsW-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// ===== design/ecal_out_if.sv =====
`timescale 1ns / 1ps
interface ecal_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] second;
  logic [5:0] minute;
  logic [4:0] hour;
  logic [2:0] weekday;
  logic [7:0] years_since_1900;
  logic [8:0] day_of_year;
  logic [3:0] month;
  logic [4:0] day_of_month;

  modport source (output valid, output second, output minute, output hour, output weekday,
                  output years_since_1900, output day_of_year, output month,
                  output day_of_month, input ready);
  modport sink   (input valid, input second, input minute, input hour, input weekday,
                  input years_since_1900, input day_of_year, input month,
                  input day_of_month, output ready);
endinterface

// ===== design/epoch_seconds_to_utc_calendar_top.sv =====
// Epoch seconds to UTC calendar converter.
// Request channel req_i carries a 32-bit unsigned count of seconds since
// 1970-01-01 00:00:00 UTC; response channel rsp_o returns second, minute,
// hour, weekday (0 is Sunday), years since 1900, day of year, month (0 is
// January) and day of month. Both use valid/ready; a transfer happens on
// a clock edge with both high. One request is in work at a time.
// The work runs in order: four passes of the shared bit-serial divider
// (32, 17, 11 and 16 bits, one quotient bit per cycle), the year loop (one
// year subtracted per cycle, 0 to 136 years), then the month search (1 to
// 12 steps), plus handoffs; the year loop sets how long a conversion takes.
// The next request is taken only after the result loads, so a request is
// not taken before the last one is through.
// Once the result is in the output register the next request is taken,
// even while the response waits; a stalled response holds its payload and
// the following result waits in the converter until the register drains.
// Reset clears the control state and the response valid flag.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module epoch_seconds_to_utc_calendar_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  ecal_in_if.sink    req_i,
  ecal_out_if.source rsp_o
);
  import ecal_pkg::*;

  ctl_state_e state_q, state_d;

  // Shared divider for the day split, minutes, hours and weekday.
  logic             div_start, div_busy, div_done;
  div_req_t         div_req;
  logic [TsW-1:0]   div_quot;
  logic [RemW-1:0]  div_rem;

  // Calendar stepper for year, month and day.
  logic             cal_start, cal_done;
  cal_res_t         cal_res;

  // Partial results held between divider passes.
  logic [DaysW-1:0] days_q;
  logic [5:0]       sec_q, min_q;
  logic [4:0]       hr_q;
  logic [2:0]       wday_q;
  logic             cap_days, cap_sec, cap_hm, cap_wday, load_rsp;
  logic             rsp_valid_q, rsp_valid_d;

  ecal_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  ecal_cal u_cal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cal_start),
    .days_i  (days_q),
    .done_o  (cal_done),
    .res_o   (cal_res)
  );

  // Next state: advance on each divider completion, then wait for the
  // calendar stepper, then for room in the output register.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CtlIdle: if (req_i.valid) state_d = CtlDay;
      CtlDay:  if (div_done) state_d = CtlMin;
      CtlMin:  if (div_done) state_d = CtlHour;
      CtlHour: if (div_done) state_d = CtlWday;
      CtlWday: if (div_done) state_d = CtlCal;
      CtlCal:  if (cal_done) state_d = CtlLoad;
      CtlLoad: if (!rsp_valid_q || rsp_o.ready) state_d = CtlIdle;
      default: state_d = CtlIdle;
    endcase
  end

  // Outputs: each divider completion captures its result and launches the
  // next pass with a left-aligned dividend; the last one starts the calendar stepper.
  always_comb begin
    req_i.ready = 1'b0;
    div_start   = 1'b0;
    div_req     = '0;
    cal_start   = 1'b0;
    cap_days    = 1'b0;
    cap_sec     = 1'b0;
    cap_hm      = 1'b0;
    cap_wday    = 1'b0;
    load_rsp    = 1'b0;
    unique case (state_q)
      CtlIdle: begin
        req_i.ready = 1'b1;
        div_start   = req_i.valid;
        div_req     = '{dividend: req_i.epoch_seconds, steps: StepsDay,
                        divisor: SecsPerDay};
      end
      CtlDay: begin
        cap_days  = div_done;
        div_start = div_done;
        div_req   = '{dividend: {div_rem, {(TsW-RemW){1'b0}}}, steps: StepsTod,
                      divisor: SixtyDiv};
      end
      CtlMin: begin
        cap_sec   = div_done;
        div_start = div_done;
        div_req   = '{dividend: {div_quot[10:0], {(TsW-11){1'b0}}},
                      steps: StepsMinOfDay, divisor: SixtyDiv};
      end
      CtlHour: begin
        cap_hm    = div_done;
        div_start = div_done;
        div_req   = '{dividend: {days_q + EpochWdayOfs, {(TsW-DaysW){1'b0}}},
                      steps: StepsWeek, divisor: WeekDiv};
      end
      CtlWday: begin
        cap_wday  = div_done;
        cal_start = div_done;
      end
      CtlLoad: begin
        load_rsp = !rsp_valid_q || rsp_o.ready;
      end
      default: ;
    endcase
  end

  // Hold the response until taken; a new load replaces a drained one.
  always_comb begin
    if (load_rsp) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CtlIdle;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_days) days_q <= div_quot[DaysW-1:0];
    if (cap_sec)  sec_q  <= div_rem[5:0];
    if (cap_hm) begin
      min_q <= div_rem[5:0];
      hr_q  <= div_quot[4:0];
    end
    if (cap_wday) wday_q <= div_rem[2:0];
    if (load_rsp) begin
      rsp_o.second           <= sec_q;
      rsp_o.minute           <= min_q;
      rsp_o.hour             <= hr_q;
      rsp_o.weekday          <= wday_q;
      rsp_o.years_since_1900 <= cal_res.years;
      rsp_o.day_of_year      <= cal_res.yday;
      rsp_o.month            <= cal_res.month;
      rsp_o.day_of_month     <= cal_res.mday;
    end
  end

  assign rsp_o.valid = rsp_valid_q;

  `ECAL_ASSERT_IMP(a_ready_div_free, req_i.ready, !div_busy,
                   "request taken while divider busy")
  `ECAL_ASSERT_IMP(a_rsp_time_ok, rsp_valid_q,
                   (rsp_o.second < 6'd60) && (rsp_o.minute < 6'd60) &&
                   (rsp_o.hour < 5'd24) && (rsp_o.weekday < 3'd7),
                   "time of day out of range")
  `ECAL_ASSERT_IMP(a_rsp_date_ok, rsp_valid_q,
                   (rsp_o.month <= MonthLast) && (rsp_o.day_of_month != 5'd0) &&
                   (rsp_o.day_of_year < DaysLeap),
                   "date out of range")
  `ECAL_ASSERT_NXT(a_load_sets_valid, load_rsp, rsp_valid_q,
                   "loaded response not flagged valid")

endmodule

// ===== design/ecal_div.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ecal_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  ecal_pkg::div_req_t          req_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [ecal_pkg::TsW-1:0]    quot_o,
  output logic [ecal_pkg::RemW-1:0]   rem_o
);
  import ecal_pkg::*;

  logic [TsW-1:0]   shift_q, shift_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [RemW-1:0]  div_q;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [RemW:0]    trial, diff;
  logic             fits;

  // One quotient bit per cycle: shift the next dividend bit into the remainder.
  assign trial = {rem_q, shift_q[TsW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = (trial >= {1'b0, div_q});

  always_comb begin
    shift_d = shift_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    if (start_i) begin
      shift_d = req_i.dividend;
      rem_d   = '0;
      cnt_d   = req_i.steps;
    end else if (cnt_q != '0) begin
      shift_d = {shift_q[TsW-2:0], fits};
      rem_d   = fits ? diff[RemW-1:0] : trial[RemW-1:0];
      cnt_d   = cnt_q - StepW'(1);
      done_d  = (cnt_q == StepW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
    if (start_i) begin
      div_q <= req_i.divisor;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign quot_o = shift_q;
  assign rem_o  = rem_q;

  `ECAL_ASSERT_IMP(a_rem_below_div, done_q, rem_q < div_q, "remainder not below divisor")
  `ECAL_ASSERT_IMP(a_start_when_free, start_i, cnt_q == '0, "divider restarted while busy")

endmodule

// ===== design/ecal_cal.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ecal_cal (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ecal_pkg::DaysW-1:0]  days_i,
  output logic                        done_o,
  output ecal_pkg::cal_res_t          res_o
);
  import ecal_pkg::*;

  cal_state_e       state_q, state_d;
  logic [DaysW-1:0] days_q;
  logic [7:0]       yoff_q;
  logic [1:0]       m4_q;
  logic [6:0]       m100_q;
  logic [8:0]       m400_q;
  logic [YdayW-1:0] yday_q, d_q;
  logic [1:0]       base_q;
  logic [3:0]       mon_q;
  logic [4:0]       mday_q;
  logic             done_q;

  logic             leap;
  logic [YdayW-1:0] len;
  logic             year_end;
  logic             month_hit;
  logic [YdayW-1:0] mstart;
  logic [YdayW-1:0] mday_full;
  logic             step_year, take_year, step_month, take_month;

  assign leap      = (m4_q == '0) && ((m100_q != '0) || (m400_q == '0));
  assign len       = leap ? DaysLeap : DaysCommon;
  assign year_end  = (days_q < {{(DaysW-YdayW){1'b0}}, len});
  assign mstart    = month_start(mon_q);
  assign month_hit = (mon_q == '0) || (mstart <= d_q);
  assign mday_full = {{(YdayW-2){1'b0}}, base_q} + d_q - mstart;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CalIdle:  if (start_i) state_d = CalYear;
      CalYear:  if (year_end) state_d = CalMonth;
      CalMonth: if (month_hit) state_d = CalIdle;
      default:  state_d = CalIdle;
    endcase
  end

  always_comb begin
    step_year  = 1'b0;
    take_year  = 1'b0;
    step_month = 1'b0;
    take_month = 1'b0;
    unique case (state_q)
      CalYear: begin
        step_year = !year_end;
        take_year = year_end;
      end
      CalMonth: begin
        step_month = !month_hit;
        take_month = month_hit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CalIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= take_month;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      days_q <= days_i;
      yoff_q <= EpochYearOfs;
      m4_q   <= EpochMod4;
      m100_q <= EpochMod100;
      m400_q <= EpochMod400;
    end else if (step_year) begin
      days_q <= days_q - {{(DaysW-YdayW){1'b0}}, len};
      yoff_q <= yoff_q + 8'd1;
      m4_q   <= m4_q + 2'd1;
      m100_q <= (m100_q == Mod100Last) ? '0 : m100_q + 7'd1;
      m400_q <= (m400_q == Mod400Last) ? '0 : m400_q + 9'd1;
    end
    if (take_year) begin
      yday_q <= days_q[YdayW-1:0];
      mon_q  <= MonthLast;
      // Days after February 28 of a leap year fold back by one.
      if (leap && (days_q[YdayW-1:0] > LeapDay - 9'd1)) begin
        d_q    <= days_q[YdayW-1:0] - 9'd1;
        base_q <= (days_q[YdayW-1:0] == LeapDay) ? MdayOnLeap : MdayBase;
      end else begin
        d_q    <= days_q[YdayW-1:0];
        base_q <= MdayBase;
      end
    end
    if (step_month) begin
      mon_q <= mon_q - 4'd1;
    end
    if (take_month) begin
      mday_q <= mday_full[4:0];
    end
  end

  assign done_o      = done_q;
  assign res_o.years = yoff_q;
  assign res_o.yday  = yday_q;
  assign res_o.month = mon_q;
  assign res_o.mday  = mday_q;

  `ECAL_ASSERT_IMP(a_month_in_range, state_q == CalMonth, mon_q <= MonthLast,
                   "month search out of range")
  `ECAL_ASSERT_IMP(a_folded_day, state_q == CalMonth, d_q < DaysCommon,
                   "folded day of year too large")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Top-level bench for the epoch-seconds to UTC calendar converter.
// A driver and a monitor run as clocked always blocks around the converter.
// The driver takes timestamps from a queue that the stimulus block fills.
// It predicts the calendar fields of every accepted request.
// The monitor checks each response against the oldest prediction.
module tb;
  import ecal_pkg::*;

  localparam int unsigned HalfPeriod    = 4;
  localparam int unsigned ResetCycles   = 10;
  localparam int unsigned NumRandom     = 1100;
  localparam int unsigned SettleCycles  = 300;
  // Worst case is a full conversion behind a long stall of the receiver.
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned MaxPrinted    = 100;
  localparam int unsigned NumYears      = 137;   // 1970 .. 2106
  localparam longint      SecsPerDayL   = 86400;
  localparam longint      TsLimit       = 64'h1_0000_0000;

  // One predicted response. The timestamp travels along for the error report.
  typedef struct packed {
    logic [TsW-1:0] ts;
    logic [5:0]     second;
    logic [5:0]     minute;
    logic [4:0]     hour;
    logic [2:0]     weekday;
    logic [7:0]     years_since_1900;
    logic [8:0]     day_of_year;
    logic [3:0]     month;
    logic [4:0]     day_of_month;
  } utc_cal_t;

  // One entry of the send queue. With drain set, the driver holds the request
  // back until every outstanding response has come in.
  typedef struct packed {
    logic           drain;
    logic [TsW-1:0] ts;
  } ts_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ecal_in_if  req_if ();
  ecal_out_if rsp_if ();

  epoch_seconds_to_utc_calendar_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  ts_req_t  ts_to_send_q[$];
  utc_cal_t expected_cal_q[$];
  int       n_sent     = 0;
  int       n_errors   = 0;
  int       idle_edges = 0;
  longint   year_start[NumYears];

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  function automatic bit is_leap(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  function automatic int unsigned month_len(input int unsigned mon, input bit leap);
    case (mon)
      1:            return leap ? 29 : 28;
      3, 5, 8, 10:  return 30;
      default:      return 31;
    endcase
  endfunction

  // Break a timestamp down into calendar fields: peel off whole years, then
  // whole months, February taking its leap length where due.
  function automatic utc_cal_t utc_calendar_of(input logic [TsW-1:0] ts);
    utc_cal_t    c;
    int unsigned tod;
    int unsigned days;
    int unsigned yr;
    int unsigned mon;
    bit          leap;
    tod  = ts % 86400;
    days = ts / 86400;
    c.ts      = ts;
    c.second  = 6'(tod % 60);
    c.minute  = 6'((tod / 60) % 60);
    c.hour    = 5'(tod / 3600);
    c.weekday = 3'((days + 4) % 7);
    yr = 1970;
    while (days >= (is_leap(yr) ? 366 : 365)) begin
      days -= is_leap(yr) ? 366 : 365;
      yr++;
    end
    leap = is_leap(yr);
    c.years_since_1900 = 8'(yr - 1900);
    c.day_of_year      = 9'(days);
    mon = 0;
    while (days >= month_len(mon, leap)) begin
      days -= month_len(mon, leap);
      mon++;
    end
    c.month        = 4'(mon);
    c.day_of_month = 5'(days + 1);
    return c;
  endfunction

  // Print one line per mismatch (up to a cap) and count every one.
  task automatic report_mismatch(input string field, input logic [TsW-1:0] ts,
                                 input logic [31:0] got, input logic [31:0] want);
    if (n_errors < MaxPrinted)
      $display("%0t: mismatch on %s for ts %0d: got %0d, expected %0d",
               $realtime, field, ts, got, want);
    n_errors++;
  endtask

  // Idle odds per hundred cycles: sender light and receiver heavy first, then
  // the other way round, then neither side idles.
  function automatic int unsigned send_idle_pct(input int sent);
    if (sent < 400) return 16;
    if (sent < 800) return 87;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct(input int sent);
    if (sent < 400) return 87;
    if (sent < 800) return 16;
    return 0;
  endfunction

  function automatic logic [TsW-1:0] random_ts();
    return $urandom();
  endfunction

  // Pick a timestamp near a year start, the leap day or the end of a year.
  // Fall back to a uniform draw when the pick leaves the 32-bit range.
  function automatic logic [TsW-1:0] boundary_ts();
    longint base;
    longint t;
    base = year_start[$urandom_range(NumYears - 1)];
    case ($urandom_range(5))
      0:       t = base - 1;
      1:       t = base;
      2:       t = base + 59 * SecsPerDayL + $urandom_range(86399);
      3:       t = base + 58 * SecsPerDayL + 86399;
      4:       t = base + 60 * SecsPerDayL;
      default: t = base + 365 * SecsPerDayL + $urandom_range(86399);
    endcase
    if (t < 0 || t >= TsLimit)
      return random_ts();
    return TsW'(t);
  endfunction

  // Driver: advance to the next request once the current one is taken, and
  // predict the response of every request that is accepted.
  always @(posedge clk_i) begin
    ts_req_t nxt;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_cal_q.push_back(utc_calendar_of(req_if.epoch_seconds));
        n_sent++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (ts_to_send_q.size() == 0) begin
          req_if.valid <= 1'b0;
        end else if (ts_to_send_q[0].drain && expected_cal_q.size() != 0) begin
          // hold off until the converter has drained
          req_if.valid <= 1'b0;
        end else if ($urandom_range(99) < send_idle_pct(n_sent)) begin
          req_if.valid <= 1'b0;
        end else begin
          nxt = ts_to_send_q.pop_front();
          req_if.valid         <= 1'b1;
          req_if.epoch_seconds <= nxt.ts;
        end
      end
    end
  end

  // Monitor: check each accepted response field by field, then drop the
  // matching prediction.
  always @(posedge clk_i) begin
    utc_cal_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_cal_q.size() == 0) begin
          report_mismatch("response with nothing outstanding", '0, '0, '0);
        end else begin
          want = expected_cal_q.pop_front();
          if (rsp_if.second !== want.second)
            report_mismatch("second", want.ts, 32'(rsp_if.second), 32'(want.second));
          if (rsp_if.minute !== want.minute)
            report_mismatch("minute", want.ts, 32'(rsp_if.minute), 32'(want.minute));
          if (rsp_if.hour !== want.hour)
            report_mismatch("hour", want.ts, 32'(rsp_if.hour), 32'(want.hour));
          if (rsp_if.weekday !== want.weekday)
            report_mismatch("weekday", want.ts, 32'(rsp_if.weekday),
                            32'(want.weekday));
          if (rsp_if.years_since_1900 !== want.years_since_1900)
            report_mismatch("years_since_1900", want.ts, 32'(rsp_if.years_since_1900),
                            32'(want.years_since_1900));
          if (rsp_if.day_of_year !== want.day_of_year)
            report_mismatch("day_of_year", want.ts, 32'(rsp_if.day_of_year),
                            32'(want.day_of_year));
          if (rsp_if.month !== want.month)
            report_mismatch("month", want.ts, 32'(rsp_if.month), 32'(want.month));
          if (rsp_if.day_of_month !== want.day_of_month)
            report_mismatch("day_of_month", want.ts, 32'(rsp_if.day_of_month),
                            32'(want.day_of_month));
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct(n_sent));
    end
  end

  // Watchdog: give up after too many cycles without a handshake on either side.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_edges = 0;
    end else begin
      idle_edges++;
      if (idle_edges >= WatchdogLimit) begin
        $display("%0t: watchdog expired", $realtime);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Queue one timestamp for the driver.
  task automatic queue_ts(input logic [TsW-1:0] ts, input bit drain = 1'b0);
    ts_req_t r;
    r.drain = drain;
    r.ts    = ts;
    ts_to_send_q.push_back(r);
  endtask

  initial begin
    longint acc;
    int     sel;
    // Hold every input low from time zero.
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.epoch_seconds = '0;
    rsp_if.ready         = 1'b0;

    // Start of each year in seconds, for stimulus near year edges.
    acc = 0;
    for (int i = 0; i < NumYears; i++) begin
      year_start[i] = acc;
      acc += (is_leap(1970 + i) ? 366 : 365) * SecsPerDayL;
    end

    // Directed: field extremes, the leap day, century years, bit patterns.
    queue_ts(32'd0);
    queue_ts(32'd1);
    queue_ts(32'd59);
    queue_ts(32'd60);
    queue_ts(32'd3599);
    queue_ts(32'd86399);
    queue_ts(32'd86400);
    queue_ts(32'd68169600);      // 29 Feb 1972
    queue_ts(32'd94694399);      // last second of 1972, day 365
    queue_ts(32'd946684799);     // last second of 1999
    queue_ts(32'd951782399);     // 28 Feb 2000, 2000 is a leap year
    queue_ts(32'd951782400);     // 29 Feb 2000
    queue_ts(32'd951868800);     // 1 Mar 2000
    queue_ts(32'd978307199);     // 31 Dec 2000, day 365
    queue_ts(32'd978307200);     // 1 Jan 2001
    queue_ts(32'd4107542399);    // 28 Feb 2100, 2100 is not a leap year
    queue_ts(32'd4107542400);    // 1 Mar 2100
    queue_ts(32'h7FFF_FFFF);
    queue_ts(32'h8000_0000);
    queue_ts(32'hAAAA_AAAA);
    queue_ts(32'h5555_5555);
    queue_ts(32'hFFFF_FFFF);     // latest date, February 2106

    // Random: uniform draws, edges of days, and edges of years and leap days.
    for (int i = 0; i < NumRandom; i++) begin
      logic [TsW-1:0] ts;
      sel = $urandom_range(9);
      if (sel < 4) begin
        ts = random_ts();
      end else if (sel < 7) begin
        ts = TsW'(longint'($urandom_range(49709)) * SecsPerDayL);
        case ($urandom_range(2))
          0:       ts = ts;
          1:       ts = ts + 86399;
          default: ts = ts + $urandom_range(86399);
        endcase
      end else begin
        ts = boundary_ts();
      end
      // pause once after the directed part and once midway
      queue_ts(ts, i == 0 || i == NumRandom / 2);
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the send queue and the outstanding responses to drain.
    while (ts_to_send_q.size() != 0 || req_if.valid || expected_cal_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
